[sv/crc16af_pkg.sv]
// ----------------------------------------------------------------------------
// crc16af_pkg
// Shared constants, types and the CRC-16/ARC byte update for the frame builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crc16af_pkg;

  localparam int unsigned FrameBytes = 10;
  localparam int unsigned CrcSpan    = 8;
  localparam int unsigned CntW       = $clog2(FrameBytes);

  localparam logic [15:0] CrcPoly    = 16'hA001;
  localparam logic [15:0] CrcInit    = 16'h0000;
  localparam logic [7:0]  StartReset = 8'hAA;
  localparam logic [7:0]  AddrReset  = 8'h01;

  localparam int unsigned PaddrW = 3;

  typedef enum logic {
    REG_START_BYTE = 1'b0,
    REG_DEV_ADDR   = 1'b1
  } reg_idx_e;

  typedef logic [CrcSpan-1:0][7:0] span_t;

  typedef struct packed {
    span_t       bytes;
    logic [15:0] crc;
  } crc_frame_t;

  function automatic logic [15:0] crc_arc_update(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[sv/crc16_arc_frame_builder.sv]
// ----------------------------------------------------------------------------
// crc16_arc_frame_builder
// A request passes through the CRC pipeline, then loads into the output shift register.
// Throughput: one frame byte per cycle unless out_ready_i stalls it; the request rate is set by
// the byte-wide output port; the CRC pipeline holds up to 8 requests in flight.
// Reset: asynchronous, active low; empties the pipeline, start byte 0xAA, address 0x01.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc16_arc_frame_builder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [crc16af_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     command_i,
  input  logic [7:0]                     payload_0_i,
  input  logic [7:0]                     payload_1_i,
  input  logic [7:0]                     payload_2_i,
  input  logic [7:0]                     payload_3_i,
  input  logic [7:0]                     payload_4_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     frame_byte_o,
  output logic                           last_byte_o
);
  import crc16af_pkg::*;

  logic [7:0] start_q, start_d;
  logic [7:0] addr_q, addr_d;
  reg_idx_e   reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    start_d = start_q;
    addr_d  = addr_q;
    prdata  = 32'h0;
    unique case (reg_idx)
      REG_START_BYTE: begin
        prdata = {24'h0, start_q};
        if (wr_en) start_d = pwdata[7:0];
      end
      REG_DEV_ADDR: begin
        prdata = {24'h0, addr_q};
        if (wr_en) addr_d = pwdata[7:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= StartReset;
      addr_q  <= AddrReset;
    end else begin
      start_q <= start_d;
      addr_q  <= addr_d;
    end
  end

  span_t      req_bytes;
  logic       pipe_valid;
  logic       pipe_ready;
  crc_frame_t pipe_frame;

  assign req_bytes = {payload_4_i, payload_3_i, payload_2_i, payload_1_i,
                      payload_0_i, command_i, addr_q, start_q};

  crc16af_crc_pipe u_crc_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_bytes_i  (req_bytes),
    .out_valid_o (pipe_valid),
    .out_ready_i (pipe_ready),
    .out_frame_o (pipe_frame)
  );

  logic [FrameBytes-1:0][7:0] shift_q, shift_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       out_fire;
  logic                       last;
  logic                       load;

  assign last       = (cnt_q == CntW'(FrameBytes - 1));
  assign out_fire   = out_valid_o && out_ready_i;
  assign pipe_ready = !busy_q || (out_fire && last);
  assign load       = pipe_ready && pipe_valid;

  always_comb begin
    shift_d = shift_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (load) begin
      shift_d = {pipe_frame.crc[15:8], pipe_frame.crc[7:0], pipe_frame.bytes};
      cnt_d   = '0;
      busy_d  = 1'b1;
    end else if (out_fire) begin
      shift_d = {8'h00, shift_q[FrameBytes-1:1]};
      cnt_d   = cnt_q + CntW'(1);
      busy_d  = !last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

  assign out_valid_o  = busy_q;
  assign frame_byte_o = shift_q[0];
  assign last_byte_o  = last;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q < CntW'(FrameBytes))
    else $error("byte counter left the frame");

  a_load_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> busy_q && cnt_q == '0)
    else $error("frame load did not restart at the first byte");

  a_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !last_byte_o |=> out_valid_o && cnt_q == $past(cnt_q) + CntW'(1))
    else $error("frame ended before its last byte");
`endif

endmodule

[sv/crc16af_crc_pipe.sv]
// ----------------------------------------------------------------------------
// crc16af_crc_pipe
// Eight-stage CRC pipeline: each stage folds one frame byte into the CRC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc16af_crc_pipe (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  crc16af_pkg::span_t      in_bytes_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output crc16af_pkg::crc_frame_t out_frame_o
);
  import crc16af_pkg::*;

  logic [CrcSpan-1:0] valid_q;
  span_t              bytes_q [CrcSpan];
  logic [15:0]        crc_q   [CrcSpan];
  logic [CrcSpan:0]   rdy;

  assign rdy[CrcSpan] = out_ready_i;

  for (genvar k = 0; k < CrcSpan; k++) begin : g_stage
    logic        src_valid;
    span_t       src_bytes;
    logic [15:0] src_crc;
    logic [15:0] crc_d;

    if (k == 0) begin : g_first
      assign src_valid = in_valid_i;
      assign src_bytes = in_bytes_i;
      assign src_crc   = CrcInit;
    end else begin : g_next
      assign src_valid = valid_q[k-1];
      assign src_bytes = bytes_q[k-1];
      assign src_crc   = crc_q[k-1];
    end

    assign crc_d  = crc_arc_update(src_crc, src_bytes[k]);
    assign rdy[k] = !valid_q[k] || rdy[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        valid_q[k] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && src_valid) begin
        bytes_q[k] <= src_bytes;
        crc_q[k]   <= crc_d;
      end
    end
  end

  assign in_ready_o        = rdy[0];
  assign out_valid_o       = valid_q[CrcSpan-1];
  assign out_frame_o.bytes = bytes_q[CrcSpan-1];
  assign out_frame_o.crc   = crc_q[CrcSpan-1];

`ifndef SYNTHESIS
  a_first_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> valid_q[0])
    else $error("accepted request did not enter the first stage");

  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(crc_q[CrcSpan-1]))
    else $error("stalled last stage lost or changed its CRC");

  a_ready_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> valid_q[0])
    else $error("first stage refused a request while empty");
`endif

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Checks crc16_arc_frame_builder. Each request is turned into its expected
// ten-byte frame (start byte, address, command, payload, CRC-16/ARC low and
// high) and every output byte is compared in order with that frame. The run
// covers register extremes, field extremes, random traffic under random
// stalls on both sides, and a final stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import crc16af_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 12;

  typedef struct packed {
    logic [7:0]      command;
    logic [4:0][7:0] payload;
  } frame_req_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_out_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PaddrW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [7:0]          command_i;
  logic [7:0]          payload_0_i;
  logic [7:0]          payload_1_i;
  logic [7:0]          payload_2_i;
  logic [7:0]          payload_3_i;
  logic [7:0]          payload_4_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [7:0]          frame_byte_o;
  logic                last_byte_o;

  logic [7:0]  sof_byte;
  logic [7:0]  dev_addr;
  frame_out_t  frame_byte_q[$];
  bit          src_gaps_on;
  bit          sink_stalls_on;
  int unsigned fail_count;
  int unsigned requests_sent;
  int unsigned bytes_checked;
  int unsigned reg_writes;
  int unsigned cycle_count;

  crc16_arc_frame_builder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .payload_0_i (payload_0_i),
    .payload_1_i (payload_1_i),
    .payload_2_i (payload_2_i),
    .payload_3_i (payload_3_i),
    .payload_4_i (payload_4_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .frame_byte_o(frame_byte_o),
    .last_byte_o (last_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t timeout after %0d cycles", $realtime, cycle_count);
      $display("crc16_arc_frame_builder verification failed");
      $finish;
    end
  end

  // Reflected CRC-16 with polynomial 0xA001, one byte at a time.
  function automatic logic [15:0] arc_crc_fold(logic [15:0] acc, logic [7:0] data);
    logic [15:0] c;
    c = acc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

  task automatic queue_expected_frame(input frame_req_t r);
    logic [9:0][7:0] fb;
    logic [15:0]     crc;
    fb[0] = sof_byte;
    fb[1] = dev_addr;
    fb[2] = r.command;
    for (int i = 0; i < 5; i++) begin
      fb[3 + i] = r.payload[i];
    end
    crc = 16'h0000;
    for (int i = 0; i < 8; i++) begin
      crc = arc_crc_fold(crc, fb[i]);
    end
    fb[8] = crc[7:0];
    fb[9] = crc[15:8];
    for (int i = 0; i < 10; i++) begin
      frame_byte_q.push_back('{data: fb[i], last: (i == 9)});
    end
  endtask

  // Output checker.
  always @(posedge clk_i) begin
    frame_out_t exp_b;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (frame_byte_q.size() == 0) begin
        fail_count++;
        $display("%0t unexpected byte: expected none, actual %h last %b",
                 $realtime, frame_byte_o, last_byte_o);
      end else begin
        exp_b = frame_byte_q.pop_front();
        bytes_checked++;
        if (frame_byte_o !== exp_b.data) begin
          fail_count++;
          $display("%0t frame_byte mismatch: expected %h, actual %h",
                   $realtime, exp_b.data, frame_byte_o);
        end
        if (last_byte_o !== exp_b.last) begin
          fail_count++;
          $display("%0t last_byte mismatch: expected %b, actual %b",
                   $realtime, exp_b.last, last_byte_o);
        end
      end
    end
  end

  // Receiver stalls.
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_request(input frame_req_t r);
    if (src_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= r.command;
    payload_0_i <= r.payload[0];
    payload_1_i <= r.payload[1];
    payload_2_i <= r.payload[2];
    payload_3_i <= r.payload[3];
    payload_4_i <= r.payload[4];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    queue_expected_frame(r);
    requests_sent++;
  endtask

  // Drop valid and hold until every frame byte has come out.
  task automatic drain_frames();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (frame_byte_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic apb_write_reg(input reg_idx_e idx, input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom_range(0, 16777215)), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_START_BYTE) begin
      sof_byte = value;
    end else begin
      dev_addr = value;
    end
    reg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[7:0] !== value) begin
      fail_count++;
      $display("%0t readback mismatch reg %s: expected %h, actual %h",
               $realtime, idx.name(), value, prdata[7:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_framing(input logic [7:0] sof, input logic [7:0] addr);
    drain_frames();
    apb_write_reg(REG_START_BYTE, sof);
    apb_write_reg(REG_DEV_ADDR, addr);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic frame_req_t rand_request();
    frame_req_t r;
    r.command = pick_byte();
    for (int i = 0; i < 5; i++) begin
      r.payload[i] = pick_byte();
    end
    return r;
  endfunction

  function automatic frame_req_t fill_request(input logic [7:0] v);
    frame_req_t r;
    r.command = v;
    for (int i = 0; i < 5; i++) begin
      r.payload[i] = v;
    end
    return r;
  endfunction

  task automatic test_reset_framing();
    send_request(fill_request(8'h00));
    send_request(fill_request(8'hFF));
    send_request(rand_request());
  endtask

  task automatic test_field_extremes();
    frame_req_t r;
    r.command = 8'h55;
    for (int i = 0; i < 5; i++) begin
      r.payload[i] = i[0] ? 8'h55 : 8'hAA;
    end
    send_request(r);
    send_request(~r);
    for (int k = 0; k < 8; k++) begin
      send_request(fill_request(8'(1 << k)));
    end
  endtask

  task automatic test_register_extremes();
    set_framing(8'h00, 8'h00);
    send_request(fill_request(8'h00));
    send_request(fill_request(8'hFF));
    set_framing(8'hFF, 8'hFF);
    send_request(fill_request(8'h00));
    send_request(fill_request(8'hFF));
    set_framing(8'h00, 8'hFF);
    send_request(rand_request());
    set_framing(8'hFF, 8'h00);
    send_request(rand_request());
  endtask

  task automatic test_random_traffic();
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    for (int p = 0; p < 5; p++) begin
      set_framing(pick_byte(), pick_byte());
      repeat (80) send_request(rand_request());
    end
  endtask

  task automatic test_full_rate();
    set_framing(StartReset, AddrReset);
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    repeat (50) send_request(rand_request());
  endtask

  initial begin
    rst_ni      <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_valid_i  <= 1'b0;
    command_i   <= '0;
    payload_0_i <= '0;
    payload_1_i <= '0;
    payload_2_i <= '0;
    payload_3_i <= '0;
    payload_4_i <= '0;
    sof_byte       = StartReset;
    dev_addr       = AddrReset;
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_framing();
    test_field_extremes();
    test_register_extremes();
    test_random_traffic();
    test_full_rate();

    drain_frames();
    repeat (20) @(posedge clk_i);
    $display("run covered %0d requests and %0d frame bytes across %0d register writes",
             requests_sent, bytes_checked, reg_writes);
    $display("framing extremes, random stalls on both sides and full-rate traffic exercised");
    if (fail_count == 0) begin
      $display("crc16_arc_frame_builder verification clean");
    end else begin
      $display("crc16_arc_frame_builder verification failed");
    end
    $finish;
  end

endmodule
